[sv/dlz_pkg.sv]
// shared types and constants of the descrambling lz decompressor
`default_nettype none
package dlz_pkg;

    // rolling descramble key
    localparam logic [7:0] KEY_INIT = 8'hF2;
    localparam logic [7:0] KEY_STEP = 8'h11;

    // token format: 10-bit distance field, 6-bit copy count
    localparam int DIST_FIELD_W = 10;
    localparam int DIST_W       = DIST_FIELD_W + 1;
    localparam int COUNT_W      = 6;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_ESCAPE_BYTE     = 4'h0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_OUTPUT_SIZE     = 4'h4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_COMPRESSED_MODE = 4'h8;

    // token parser phase
    localparam logic [1:0] PH_LITERAL = 2'd0;
    localparam logic [1:0] PH_LOW     = 2'd1;
    localparam logic [1:0] PH_HIGH    = 2'd2;

    typedef struct packed {
        logic [7:0]  escape_byte;
        logic [31:0] output_size;
        logic        compressed_mode;
    } t_cfg;

endpackage
`default_nettype wire

[sv/descramble_lz_decompressor_core.sv]
// descrambling lz decompressor with escape-byte tokens, top level
//
// Input stream (s side): one stored byte per item in tdata, tuser marks the
// first byte of an asset and restarts key, parser, counters and window.
// Output stream (m side): one decoded byte per item in tdata, tlast marks
// the byte that completes output_size, tuser flags a copy from before the
// asset start (byte reads as zero).
// Literals and plain-mode bytes: one input item per cycle while the output
// is not stalled, the result shows in the cycle after acceptance from the
// output register. Copy tokens: the input stalls while the copy runs; each
// copied byte goes through a history ram read, then output and write back,
// and a last visit to the read state closes the copy. A copy from before
// the asset start skips the ram read and gives a zero byte directly.
// The history window is one ram with a separate write port and read port.
// Once output_size bytes are produced, further items are taken and dropped.
// Reset clears the parser, counters, key and output valid flag; the output
// payload and the history ram are not cleared. A stall on the output holds
// the output register and backs up the parser and input, no item is lost.
`default_nettype none
module descramble_lz_decompressor_core #(
    parameter int WINDOW_DEPTH = 1024
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input item stream
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire  [7:0]                        i_s_tdata,  // [7:0] raw_byte
    input  wire                               i_s_tuser,  // [0] first_of_asset
    // output item stream
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [7:0]                        o_m_tdata,  // [7:0] out_byte
    output logic                              o_m_tlast,  // last_of_asset
    output logic                              o_m_tuser,  // [0] bad_reference
    // configuration
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [dlz_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import dlz_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_CP_RD, ST_CP_WR} t_state;

    t_cfg cfg;

    t_state         r_state, n_state;
    logic [7:0]     r_key, n_key;
    logic [1:0]     r_phase, n_phase;
    logic [7:0]     r_held, n_held;
    logic [31:0]    r_pc, n_pc;
    logic [AW-1:0]  r_wp, n_wp;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic           r_ovalid;
    logic [7:0]     r_obyte;
    logic           r_olast, r_obad;

    logic           accept, slot_free, done;
    logic [7:0]     key_eff, b;
    logic           emit, e_bad;
    logic [7:0]     e_byte;
    logic           e_last;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_wa, ram_ra;
    logic [7:0]     ram_rd;

    dlz_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dlz_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (e_byte),
        .i_re    (ram_re),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    // handshakes
    assign slot_free  = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && slot_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_obad;

    // descramble the incoming byte
    assign key_eff = i_s_tuser ? KEY_INIT : r_key;
    assign b       = i_s_tdata ^ key_eff;

    // parser, copy sequencer and history write
    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_phase = r_phase;
        n_held  = r_held;
        n_pc    = r_pc;
        n_wp    = r_wp;
        n_cnt   = r_cnt;
        n_dist  = r_dist;
        emit    = 1'b0;
        e_bad   = 1'b0;
        e_byte  = b;
        e_last  = 1'b0;
        ram_we  = 1'b0;
        ram_wa  = r_wp;
        ram_re  = 1'b0;
        ram_ra  = r_wp - r_dist[AW-1:0];
        done    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_s_tuser) begin
                        n_phase = PH_LITERAL;
                        n_held  = 8'h00;
                        n_pc    = 32'h0;
                        n_wp    = '0;
                    end
                    n_key = key_eff + KEY_STEP;
                    if (n_pc < cfg.output_size) begin
                        if (!cfg.compressed_mode) begin
                            n_phase = PH_LITERAL;
                            emit    = 1'b1;
                        end else if (n_phase == PH_LOW) begin
                            n_held  = b;
                            n_phase = PH_HIGH;
                        end else if (n_phase == PH_HIGH) begin
                            n_phase = PH_LITERAL;
                            if (n_held == 8'h00 && b == 8'h00) begin
                                emit   = 1'b1;
                                e_byte = cfg.escape_byte;
                            end else begin
                                n_cnt  = b[7:2];
                                n_dist = {1'b0, b[1:0], n_held} + DIST_W'(1);
                                if (b[7:2] != '0) begin
                                    n_state = ST_CP_RD;
                                end
                            end
                        end else begin
                            n_phase = PH_LITERAL;
                            if (b != cfg.escape_byte) begin
                                emit = 1'b1;
                            end else begin
                                n_phase = PH_LOW;
                            end
                        end
                    end
                end
            end
            ST_CP_RD: begin
                done = (r_cnt == '0) || (r_pc >= cfg.output_size);
                if (done) begin
                    n_state = ST_IDLE;
                end else if ({21'h0, r_dist} > r_pc) begin
                    // reference before the asset start
                    if (slot_free) begin
                        emit   = 1'b1;
                        e_bad  = 1'b1;
                        e_byte = 8'h00;
                        n_cnt  = r_cnt - COUNT_W'(1);
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = ST_CP_WR;
                end
            end
            ST_CP_WR: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_byte  = ram_rd;
                    n_cnt   = r_cnt - COUNT_W'(1);
                    n_state = ST_CP_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // store emitted byte and advance counters
        if (emit) begin
            ram_we = 1'b1;
            ram_wa = n_wp;
            n_wp   = n_wp + AW'(1);
            n_pc   = n_pc + 32'd1;
            e_last = (n_pc == cfg.output_size);
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_key    <= KEY_INIT;
            r_phase  <= PH_LITERAL;
            r_held   <= 8'h00;
            r_pc     <= 32'h0;
            r_wp     <= '0;
            r_cnt    <= '0;
            r_dist   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_key   <= n_key;
            r_phase <= n_phase;
            r_held  <= n_held;
            r_pc    <= n_pc;
            r_wp    <= n_wp;
            r_cnt   <= n_cnt;
            r_dist  <= n_dist;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= e_byte;
            r_olast <= e_last;
            r_obad  <= e_bad;
        end
    end

    // history read and write never share a cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("history read and write in the same cycle");

    // a history read is always followed by the write-back state
    a_read_then_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_state == ST_CP_WR))
        else $error("history read not followed by copy write state");

    // a bad reference always carries a zero byte
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 8'h00))
        else $error("bad reference with nonzero byte");

    // input is held off while a copy runs
    a_copy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept)
        else $error("item accepted during a copy");

endmodule
`default_nettype wire

[sv/dlz_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module dlz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[sv/dlz_cfg.sv]
// apb configuration registers of the decompressor
`default_nettype none
module dlz_cfg (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [dlz_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output dlz_pkg::t_cfg                       o_cfg
);
    import dlz_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escape_byte     <= 8'h00;
            r_cfg.output_size     <= 32'h0;
            r_cfg.compressed_mode <= 1'b1;
        end else if (wr_en) begin
            unique case (paddr)
                ADDR_ESCAPE_BYTE:     r_cfg.escape_byte     <= pwdata[7:0];
                ADDR_OUTPUT_SIZE:     r_cfg.output_size     <= pwdata;
                ADDR_COMPRESSED_MODE: r_cfg.compressed_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr)
            ADDR_ESCAPE_BYTE:     prdata = {24'h0, r_cfg.escape_byte};
            ADDR_OUTPUT_SIZE:     prdata = r_cfg.output_size;
            ADDR_COMPRESSED_MODE: prdata = {31'h0, r_cfg.compressed_mode};
            default:              prdata = 32'h0;
        endcase
    end

endmodule
`default_nettype wire
